// ----- rtl/core/bsc_pkg.sv -----
// Shared types, constants and character decode for the bracket syntax checker.
package bsc_pkg;

	localparam int STATUS_W            = 2;
	localparam int SYN_W               = 15;
	localparam int SCORE_W             = 63;
	localparam int DEFAULT_STACK_DEPTH = 32;

	localparam logic [STATUS_W-1:0] STATUS_BALANCED   = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_INCOMPLETE = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_CORRUPTED  = 2'd2;
	localparam logic [STATUS_W-1:0] STATUS_FAULT      = 2'd3;

	localparam logic [7:0] CH_OPEN_PAREN  = 8'h28;
	localparam logic [7:0] CH_OPEN_SQUARE = 8'h5B;
	localparam logic [7:0] CH_OPEN_CURLY  = 8'h7B;
	localparam logic [7:0] CH_OPEN_ANGLE  = 8'h3C;
	localparam logic [7:0] CH_CLOSE_PAREN  = 8'h29;
	localparam logic [7:0] CH_CLOSE_SQUARE = 8'h5D;
	localparam logic [7:0] CH_CLOSE_CURLY  = 8'h7D;
	localparam logic [7:0] CH_CLOSE_ANGLE  = 8'h3E;

	localparam logic [1:0] KIND_PAREN  = 2'd0;
	localparam logic [1:0] KIND_SQUARE = 2'd1;
	localparam logic [1:0] KIND_CURLY  = 2'd2;
	localparam logic [1:0] KIND_ANGLE  = 2'd3;

	typedef struct packed {
		logic       is_open;
		logic       is_close;
		logic [1:0] kind;
	} char_class_t;

	function automatic char_class_t classify(input logic [7:0] code);
		char_class_t c;
		c = '{is_open: 1'b0, is_close: 1'b0, kind: KIND_PAREN};
		case (code)
			CH_OPEN_PAREN:   c = '{is_open: 1'b1, is_close: 1'b0, kind: KIND_PAREN};
			CH_OPEN_SQUARE:  c = '{is_open: 1'b1, is_close: 1'b0, kind: KIND_SQUARE};
			CH_OPEN_CURLY:   c = '{is_open: 1'b1, is_close: 1'b0, kind: KIND_CURLY};
			CH_OPEN_ANGLE:   c = '{is_open: 1'b1, is_close: 1'b0, kind: KIND_ANGLE};
			CH_CLOSE_PAREN:  c = '{is_open: 1'b0, is_close: 1'b1, kind: KIND_PAREN};
			CH_CLOSE_SQUARE: c = '{is_open: 1'b0, is_close: 1'b1, kind: KIND_SQUARE};
			CH_CLOSE_CURLY:  c = '{is_open: 1'b0, is_close: 1'b1, kind: KIND_CURLY};
			CH_CLOSE_ANGLE:  c = '{is_open: 1'b0, is_close: 1'b1, kind: KIND_ANGLE};
			default:         c = '{is_open: 1'b0, is_close: 1'b0, kind: KIND_PAREN};
		endcase
		return c;
	endfunction

	// Points for the first illegal closer of a line.
	function automatic logic [SYN_W-1:0] closer_points(input logic [1:0] kind);
		logic [SYN_W-1:0] p;
		case (kind)
			KIND_PAREN:  p = 15'd3;
			KIND_SQUARE: p = 15'd57;
			KIND_CURLY:  p = 15'd1197;
			KIND_ANGLE:  p = 15'd25137;
			default:     p = '0;
		endcase
		return p;
	endfunction

endpackage

// ----- rtl/core/bsc_score_step.sv -----
// One base-5 step of the completion score, saturating at the field maximum.
module bsc_score_step
	import bsc_pkg::*;
(
	input  logic [SCORE_W-1:0] score,
	input  logic [1:0]         kind,
	output logic [SCORE_W-1:0] score_next
);

	logic [SCORE_W+2:0] times5;
	logic [SCORE_W+2:0] sum;

	// score*5 as shift plus add, then add digit kind+1
	assign times5 = {1'b0, score, 2'b00} + {3'b000, score};
	assign sum    = times5 + {{(SCORE_W+1){1'b0}}, kind} + {{(SCORE_W+2){1'b0}}, 1'b1};

	// any bit at or above the field width means the result passed the maximum
	assign score_next = (|sum[SCORE_W+2:SCORE_W]) ? {SCORE_W{1'b1}} : sum[SCORE_W-1:0];

endmodule

// ----- rtl/core/bracket_syntax_checker.sv -----
// Top level of the bracket syntax checker: stack, sequencer and result register.
//
//  channel | dir | signals                            | payload
//  --------+-----+------------------------------------+---------------------------------------
//  s_      | in  | s_tvalid s_tready s_tdata s_tlast  | tdata[7:0] char_code, tlast last_of_line
//  m_      | out | m_tvalid m_tready m_tdata m_tuser  | tuser line_status, tdata scores
//
//  Sequence: an opener, any other byte or an ignored closer is taken in ST_IDLE alone; a
//  closer that pops also passes ST_POP (the stack memory read is registered). A line end
//  adds ST_END and ST_DONE, and an incomplete line adds ST_UNWIND, one stack entry per
//  cycle through the score step unit, then a step to fold the last entry and one to leave.
//  Reset: arst_n clears the sequencer, level, flags and the result register;
//  the stack memory holds no reset and its read data is used only for entries below the level.
//  Stalls: a held result blocks the next line end in ST_DONE, and the input with it (s_tready is low outside ST_IDLE).
module bracket_syntax_checker
	import bsc_pkg::*;
#(
	parameter int STACK_DEPTH = DEFAULT_STACK_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] char_code
	input  logic        s_tlast,  // last_of_line
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [79:0] m_tdata,  // [14:0] syntax_score, [77:15] completion_score, [79:78] zero
	output logic [1:0]  m_tuser   // [1:0] line_status
);

	localparam int LVL_W  = $clog2(STACK_DEPTH + 1);
	localparam int ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_POP,
		ST_END,
		ST_UNWIND,
		ST_DONE
	} state_t;

	state_t             state_q;
	logic [LVL_W-1:0]   lvl_q;
	logic               corrupt_q;
	logic               fault_q;
	logic [SYN_W-1:0]   synscore_q;
	logic [1:0]         kind_q;
	logic               last_q;
	logic [LVL_W-1:0]   unw_idx_q;
	logic               rd_pend_q;
	logic [SCORE_W-1:0] score_q;

	logic               m_tvalid_q;
	logic [STATUS_W-1:0] out_status_q;
	logic [SYN_W-1:0]   out_syn_q;
	logic [SCORE_W-1:0] out_comp_q;

	// bracket stack: one write port (push), one registered read port
	logic [1:0]         stack_mem [STACK_DEPTH];
	logic [1:0]         rd_data_q;
	logic [ADDR_W-1:0]  rd_addr;
	logic               push;

	logic               in_xfer;
	logic               line_active;
	logic               out_free;
	char_class_t        cls;
	logic [LVL_W-1:0]   lvl_m1;
	logic [LVL_W-1:0]   unw_m1;
	logic [SCORE_W-1:0] score_next;

	assign cls         = classify(s_tdata);
	assign s_tready    = (state_q == ST_IDLE);
	assign in_xfer     = s_tvalid && s_tready;
	assign line_active = !corrupt_q && !fault_q;
	assign out_free    = !m_tvalid_q || m_tready;
	assign lvl_m1      = lvl_q - LVL_W'(1);
	assign unw_m1      = unw_idx_q - LVL_W'(1);
	assign push        = in_xfer && line_active && cls.is_open
	                     && (lvl_q < LVL_W'(STACK_DEPTH));

	// read the top of stack on a closer transfer, or walk down during unwind
	always_comb begin
		if (state_q == ST_UNWIND) begin
			rd_addr = unw_m1[ADDR_W-1:0];
		end else begin
			rd_addr = lvl_m1[ADDR_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			stack_mem[lvl_q[ADDR_W-1:0]] <= cls.kind;
		end
		rd_data_q <= stack_mem[rd_addr];
	end

	bsc_score_step u_score_step (
		.score      (score_q),
		.kind       (rd_data_q),
		.score_next (score_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			lvl_q        <= '0;
			corrupt_q    <= 1'b0;
			fault_q      <= 1'b0;
			synscore_q   <= '0;
			kind_q       <= KIND_PAREN;
			last_q       <= 1'b0;
			unw_idx_q    <= '0;
			rd_pend_q    <= 1'b0;
			score_q      <= '0;
			m_tvalid_q   <= 1'b0;
			out_status_q <= STATUS_BALANCED;
			out_syn_q    <= '0;
			out_comp_q   <= '0;
		end else begin
			// load a new result, or drop the one just taken by the receiver
			if ((state_q == ST_DONE) && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						kind_q <= cls.kind;
						last_q <= s_tlast;
						if (line_active && cls.is_open) begin
							// push, or flag overflow when full
							if (lvl_q < LVL_W'(STACK_DEPTH)) begin
								lvl_q <= lvl_q + LVL_W'(1);
							end else begin
								fault_q <= 1'b1;
							end
						end
						if (line_active && cls.is_close) begin
							if (lvl_q == '0) begin
								fault_q <= 1'b1;
							end else begin
								// drop the level now, compare the popped kind next cycle
								lvl_q   <= lvl_m1;
								state_q <= ST_POP;
							end
						end
						if (s_tlast && !(line_active && cls.is_close && lvl_q != '0)) begin
							state_q <= ST_END;
						end
					end
				end
				ST_POP: begin
					if (rd_data_q != kind_q) begin
						corrupt_q  <= 1'b1;
						synscore_q <= closer_points(kind_q);
					end
					state_q <= last_q ? ST_END : ST_IDLE;
				end
				ST_END: begin
					score_q   <= '0;
					unw_idx_q <= lvl_q;
					rd_pend_q <= 1'b0;
					if (line_active && lvl_q != '0) begin
						state_q <= ST_UNWIND;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_UNWIND: begin
					// read one entry per cycle from the top; fold the previous one in
					if (unw_idx_q != '0) begin
						unw_idx_q <= unw_m1;
						rd_pend_q <= 1'b1;
					end else begin
						rd_pend_q <= 1'b0;
					end
					if (rd_pend_q) begin
						score_q <= score_next;
					end
					if (unw_idx_q == '0 && !rd_pend_q) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					// hold until the result register frees up, then start a clean line
					if (out_free) begin
						if (fault_q) begin
							out_status_q <= STATUS_FAULT;
							out_syn_q    <= '0;
							out_comp_q   <= '0;
						end else if (corrupt_q) begin
							out_status_q <= STATUS_CORRUPTED;
							out_syn_q    <= synscore_q;
							out_comp_q   <= '0;
						end else if (lvl_q != '0) begin
							out_status_q <= STATUS_INCOMPLETE;
							out_syn_q    <= '0;
							out_comp_q   <= score_q;
						end else begin
							out_status_q <= STATUS_BALANCED;
							out_syn_q    <= '0;
							out_comp_q   <= '0;
						end
						lvl_q      <= '0;
						corrupt_q  <= 1'b0;
						fault_q    <= 1'b0;
						synscore_q <= '0;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = out_status_q;
	assign m_tdata  = {2'b00, out_comp_q, out_syn_q};

	// the stack level never passes the configured depth
	assert property (@(posedge clk) disable iff (!arst_n)
		lvl_q <= LVL_W'(STACK_DEPTH))
		else $error("stack level above depth");

	// a delivered result carries only the score that belongs to its status
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != STATUS_CORRUPTED) |-> m_tdata[14:0] == '0)
		else $error("syntax score on a line that is not corrupted");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != STATUS_INCOMPLETE) |-> m_tdata[77:15] == '0)
		else $error("completion score on a line that is not incomplete");

	// loading a result leaves the line state clean for the next line
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) && out_free |=> (lvl_q == '0) && !corrupt_q && !fault_q)
		else $error("line state not cleared after result");

endmodule
